/* hdl/sct_pkg.sv */
// shared types and byte codes for the source character tokenizer
`timescale 1ns / 1ps
package sct_pkg;

   typedef enum logic [2:0] {
      KIND_IDENT  = 3'd0,
      KIND_NUMBER = 3'd1,
      KIND_PUNCT  = 3'd2,
      KIND_STRING = 3'd3,
      KIND_CHAR   = 3'd4
   } kind_type;

   // one tagged byte of a token, line and column travel beside it
   typedef struct packed {
      logic [7:0] char_code;
      kind_type   kind;
      logic       start;
      logic       empty;
      logic       error;
   } tok_type;

   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [7:0] CHAR_DQUOTE     = 8'h22;
   localparam logic [7:0] CHAR_QUOTE      = 8'h27;
   localparam logic [7:0] CHAR_STAR       = 8'h2A;
   localparam logic [7:0] CHAR_PLUS       = 8'h2B;
   localparam logic [7:0] CHAR_DOT        = 8'h2E;
   localparam logic [7:0] CHAR_SLASH      = 8'h2F;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

endpackage

/* hdl/sct_req_if.sv */
// request channel interface: one source byte per transaction
`timescale 1ns / 1ps
interface sct_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       end_of_input;

   modport source (output valid, char_in, end_of_input, input ready);
   modport sink   (input valid, char_in, end_of_input, output ready);
endinterface

/* hdl/sct_rsp_if.sv */
// response channel interface: one tagged token byte per transaction
`timescale 1ns / 1ps
interface sct_rsp_if #(
   parameter int LINE_BITS   = 20,
   parameter int COLUMN_BITS = 16
);
   logic                   valid;
   logic                   ready;
   logic [7:0]             char_out;
   logic [2:0]             token_kind;
   logic                   token_start;
   logic                   empty_body;
   logic                   lex_error;
   logic [LINE_BITS-1:0]   line_number;
   logic [COLUMN_BITS-1:0] column_number;
   logic                   last;

   modport source (output valid, char_out, token_kind, token_start, empty_body, lex_error,
                   line_number, column_number, last, input ready);
   modport sink   (input valid, char_out, token_kind, token_start, empty_body, lex_error,
                   line_number, column_number, last, output ready);
endinterface

/* hdl/sct_lexer.sv */
// lexer state machine with line and column counters, up to two tagged bytes per step
`timescale 1ns / 1ps
module sct_lexer #(
   parameter int LINE_BITS   = 20,
   parameter int COLUMN_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [7:0]             char_in,
   input  logic                   end_of_input,
   output logic [1:0]             result_count,
   output sct_pkg::tok_type       tok0,
   output sct_pkg::tok_type       tok1,
   output logic [COLUMN_BITS-1:0] col0,
   output logic [COLUMN_BITS-1:0] col1,
   output logic [LINE_BITS-1:0]   line
);
   import sct_pkg::*;

   typedef enum logic [3:0] {
      MODE_NORMAL    = 4'd0,
      MODE_SLASH     = 4'd1,
      MODE_LINECMT   = 4'd2,
      MODE_BLOCK     = 4'd3,
      MODE_BLOCKSTAR = 4'd4,
      MODE_IDENT     = 4'd5,
      MODE_NUMBER    = 4'd6,
      MODE_STRING    = 4'd7,
      MODE_CHAR1     = 4'd8,
      MODE_CHAR2     = 4'd9,
      MODE_PLUS      = 4'd10
   } mode_type;

   typedef struct packed {
      logic     emit;
      tok_type  tok;
      mode_type mode;
      logic     save_slash;
      logic     clear_body;
   } normal_type;

   mode_type               mode_ff, mode_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in;
   logic [COLUMN_BITS-1:0] slash_col_ff, slash_col_in;
   logic                   body_seen_ff, body_seen_in;
   normal_type             nb;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic tok_type make_tok(input logic [7:0] c, input kind_type k,
                                        input logic s, input logic e, input logic err);
      tok_type t;
      t.char_code = c;
      t.kind      = k;
      t.start     = s;
      t.empty     = e;
      t.error     = err;
      return t;
   endfunction

   // dispatch of a byte seen in normal mode
   function automatic normal_type normal_byte(input logic [7:0] c);
      normal_type n;
      n.emit       = 1'b1;
      n.tok        = make_tok(c, KIND_PUNCT, 1'b1, 1'b0, 1'b0);
      n.mode       = MODE_NORMAL;
      n.save_slash = 1'b0;
      n.clear_body = 1'b0;
      priority if (c == CHAR_SLASH) begin
         n.emit       = 1'b0;
         n.mode       = MODE_SLASH;
         n.save_slash = 1'b1;
      end else if (is_alpha(c)) begin
         n.tok.kind = KIND_IDENT;
         n.mode     = MODE_IDENT;
      end else if (is_digit(c)) begin
         n.tok.kind = KIND_NUMBER;
         n.mode     = MODE_NUMBER;
      end else if (c == CHAR_DQUOTE) begin
         n.mode       = MODE_STRING;
         n.clear_body = 1'b1;
      end else if (c == CHAR_QUOTE) begin
         n.mode = MODE_CHAR1;
      end else if (c == CHAR_PLUS) begin
         n.mode = MODE_PLUS;
      end else if (is_space(c)) begin
         n.emit = 1'b0;
      end else begin
         n.emit = 1'b1;
      end
      return n;
   endfunction

   assign nb   = normal_byte(char_in);
   assign line = line_ff;

   always_comb begin
      mode_in      = mode_ff;
      line_in      = line_ff;
      col_in       = col_ff;
      slash_col_in = slash_col_ff;
      body_seen_in = body_seen_ff;
      result_count = 2'd0;
      tok0         = make_tok(char_in, KIND_PUNCT, 1'b1, 1'b0, 1'b0);
      tok1         = make_tok(char_in, KIND_PUNCT, 1'b1, 1'b0, 1'b0);
      col0         = col_ff;
      col1         = col_ff;
      if (end_of_input) begin
         // flush a held-back slash, counters hold
         if (mode_ff == MODE_SLASH) begin
            tok0         = make_tok(CHAR_SLASH, KIND_PUNCT, 1'b1, 1'b0, 1'b0);
            col0         = slash_col_ff;
            result_count = 2'd1;
         end
         mode_in      = MODE_NORMAL;
         body_seen_in = 1'b0;
      end else begin
         unique case (mode_ff)
            MODE_SLASH: begin
               if (char_in == CHAR_SLASH) begin
                  mode_in = MODE_LINECMT;
               end else if (char_in == CHAR_STAR) begin
                  mode_in = MODE_BLOCK;
               end else begin
                  // slash goes out first, then the byte itself in normal mode
                  tok0         = make_tok(CHAR_SLASH, KIND_PUNCT, 1'b1, 1'b0, 1'b0);
                  col0         = slash_col_ff;
                  tok1         = nb.tok;
                  result_count = nb.emit ? 2'd2 : 2'd1;
                  mode_in      = nb.mode;
                  if (nb.save_slash) slash_col_in = col_ff;
                  if (nb.clear_body) body_seen_in = 1'b0;
               end
            end
            MODE_LINECMT: begin
               if (char_in == CHAR_NEWLINE) mode_in = MODE_NORMAL;
            end
            MODE_BLOCK: begin
               if (char_in == CHAR_STAR) mode_in = MODE_BLOCKSTAR;
            end
            MODE_BLOCKSTAR: begin
               // any byte but slash, a star too, goes back to the body
               mode_in = (char_in == CHAR_SLASH) ? MODE_NORMAL : MODE_BLOCK;
            end
            MODE_IDENT, MODE_NUMBER, MODE_PLUS, MODE_NORMAL: begin
               if (mode_ff == MODE_IDENT && (is_alpha(char_in) || is_digit(char_in) ||
                                             char_in == CHAR_UNDERSCORE)) begin
                  tok0         = make_tok(char_in, KIND_IDENT, 1'b0, 1'b0, 1'b0);
                  result_count = 2'd1;
               end else if (mode_ff == MODE_NUMBER &&
                            (is_digit(char_in) || char_in == CHAR_DOT)) begin
                  tok0         = make_tok(char_in, KIND_NUMBER, 1'b0, 1'b0, 1'b0);
                  result_count = 2'd1;
               end else if (mode_ff == MODE_PLUS && char_in == CHAR_PLUS) begin
                  tok0         = make_tok(char_in, KIND_PUNCT, 1'b0, 1'b0, 1'b0);
                  result_count = 2'd1;
                  mode_in      = MODE_NORMAL;
               end else begin
                  tok0         = nb.tok;
                  result_count = nb.emit ? 2'd1 : 2'd0;
                  mode_in      = nb.mode;
                  if (nb.save_slash) slash_col_in = col_ff;
                  if (nb.clear_body) body_seen_in = 1'b0;
               end
            end
            MODE_STRING: begin
               if (char_in == CHAR_DQUOTE) begin
                  if (!body_seen_ff) begin
                     tok0         = make_tok(8'h00, KIND_STRING, 1'b1, 1'b1, 1'b0);
                     tok1         = make_tok(char_in, KIND_PUNCT, 1'b1, 1'b0, 1'b0);
                     result_count = 2'd2;
                  end else begin
                     tok0         = make_tok(char_in, KIND_PUNCT, 1'b1, 1'b0, 1'b0);
                     result_count = 2'd1;
                  end
                  mode_in      = MODE_NORMAL;
                  body_seen_in = 1'b0;
               end else begin
                  tok0         = make_tok(char_in, KIND_STRING, !body_seen_ff, 1'b0, 1'b0);
                  result_count = 2'd1;
                  body_seen_in = 1'b1;
               end
            end
            MODE_CHAR1: begin
               tok0         = make_tok(char_in, KIND_CHAR, 1'b1, 1'b0, 1'b0);
               result_count = 2'd1;
               mode_in      = MODE_CHAR2;
            end
            MODE_CHAR2: begin
               if (char_in == CHAR_QUOTE)
                  tok0 = make_tok(char_in, KIND_PUNCT, 1'b1, 1'b0, 1'b0);
               else
                  tok0 = make_tok(char_in, KIND_PUNCT, 1'b0, 1'b0, 1'b1);
               result_count = 2'd1;
               mode_in      = MODE_NORMAL;
            end
            default: begin
               tok0         = nb.tok;
               result_count = nb.emit ? 2'd1 : 2'd0;
               mode_in      = nb.mode;
               if (nb.save_slash) slash_col_in = col_ff;
               if (nb.clear_body) body_seen_in = 1'b0;
            end
         endcase
         // saturating position counters
         if (char_in == CHAR_NEWLINE) begin
            if (line_ff != {LINE_BITS{1'b1}}) line_in = line_ff + LINE_BITS'(1);
            col_in = '0;
         end else if (col_ff != {COLUMN_BITS{1'b1}}) begin
            col_in = col_ff + COLUMN_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NORMAL;
         line_ff      <= LINE_BITS'(1);
         col_ff       <= '0;
         slash_col_ff <= '0;
         body_seen_ff <= 1'b0;
      end else if (fire) begin
         mode_ff      <= mode_in;
         line_ff      <= line_in;
         col_ff       <= col_in;
         slash_col_ff <= slash_col_in;
         body_seen_ff <= body_seen_in;
      end
   end

endmodule

/* hdl/sct_result_fifo.sv */
// four-entry result queue taking up to two entries per cycle and giving one
`timescale 1ns / 1ps
module sct_result_fifo #(
   parameter int DATA_BITS = 52
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push0,
   input  logic                 push1,
   input  logic [DATA_BITS-1:0] data0,
   input  logic [DATA_BITS-1:0] data1,
   output logic                 space_ok,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [DATA_BITS-1:0] out_data
);
   localparam int DEPTH    = 4;
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 pop;

   assign space_ok  = count_ff <= CNT_BITS'(DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[rd_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in    = wr_ff + PTR_BITS'(push0) + PTR_BITS'(push1);
      rd_in    = rd_ff + PTR_BITS'(pop);
      count_in = count_ff + CNT_BITS'(push0) + CNT_BITS'(push1) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push0) mem_ff[wr_ff] <= data0;
      if (push1) mem_ff[wr_ff + PTR_BITS'(1)] <= data1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push0 |-> space_ok)
      else $error("result queue written without room for two entries");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      push1 |-> push0)
      else $error("second result pushed without a first");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("result queue fill count beyond depth");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CNT_BITS'(1) && pop && !push0) |=> !out_valid)
      else $error("result queue still valid after last entry taken");
`endif

endmodule

/* hdl/source_char_tokenizer.sv */
// top level of the source character tokenizer: lexer step feeding a result queue
`timescale 1ns / 1ps
// channel       | dir | transaction
// req_channel   | in  | one source byte, or an end-of-input marker
// rsp_channel   | out | one tagged token byte with line, column and last flag
//
// one request transaction is taken per cycle while the queue has room; the lexer
// step is a single pass from the request to the four-entry result queue, which
// takes up to two results a step, so a step giving two results is two responses.
// req ready is high while the queue has room for two entries, so stalls on the
// response side back up through the queue only.
// synchronous reset: normal mode, line one, column zero, queue empty.
module source_char_tokenizer #(
   parameter int LINE_BITS   = 20,
   parameter int COLUMN_BITS = 16
) (
   input logic       clock,
   input logic       reset,
   sct_req_if.sink   req_channel,
   sct_rsp_if.source rsp_channel
);
   import sct_pkg::*;

   localparam int TOK_BITS  = $bits(tok_type);
   localparam int DATA_BITS = TOK_BITS + LINE_BITS + COLUMN_BITS + 1;

   logic                   fire;
   logic [1:0]             result_count;
   tok_type                tok0, tok1, tok_out;
   logic [COLUMN_BITS-1:0] col0, col1, col_out;
   logic [LINE_BITS-1:0]   line, line_out;
   logic                   last_out;
   logic                   space_ok;
   logic                   push0, push1;
   logic [DATA_BITS-1:0]   data0, data1, out_data;

   // a request is taken whenever the queue can absorb a worst-case step
   assign req_channel.ready = space_ok;
   assign fire              = req_channel.valid && space_ok;

   sct_lexer #(
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS)
   ) u_lexer (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .char_in      (req_channel.char_in),
      .end_of_input (req_channel.end_of_input),
      .result_count (result_count),
      .tok0         (tok0),
      .tok1         (tok1),
      .col0         (col0),
      .col1         (col1),
      .line         (line)
   );

   // both results of a step share the line; last marks the final one
   assign push0 = fire && (result_count != 2'd0);
   assign push1 = fire && (result_count == 2'd2);
   assign data0 = {tok0, line, col0, result_count == 2'd1};
   assign data1 = {tok1, line, col1, 1'b1};

   sct_result_fifo #(
      .DATA_BITS (DATA_BITS)
   ) u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .push0     (push0),
      .push1     (push1),
      .data0     (data0),
      .data1     (data1),
      .space_ok  (space_ok),
      .out_valid (rsp_channel.valid),
      .out_ready (rsp_channel.ready),
      .out_data  (out_data)
   );

   // unpack the queue head onto the response fields
   assign {tok_out, line_out, col_out, last_out} = out_data;

   assign rsp_channel.char_out      = tok_out.char_code;
   assign rsp_channel.token_kind    = tok_out.kind;
   assign rsp_channel.token_start   = tok_out.start;
   assign rsp_channel.empty_body    = tok_out.empty;
   assign rsp_channel.lex_error     = tok_out.error;
   assign rsp_channel.line_number   = line_out;
   assign rsp_channel.column_number = col_out;
   assign rsp_channel.last          = last_out;

endmodule
